// File: rtl/mksd_pkg.sv
// Shared types, keyword tables and compare function for the keyword stream detector.
`default_nettype none

package mksd_pkg;

    // Keyword table geometry
    localparam int unsigned KEY_COUNT  = 8;
    localparam int unsigned FLAG_COUNT = 5;
    localparam int unsigned MAX_LEN    = 18;
    localparam int unsigned CELL_COUNT = MAX_LEN - 1;
    localparam int unsigned POS_W      = $clog2(MAX_LEN);
    localparam int unsigned OUT_W      = 8;

    typedef logic [KEY_COUNT-1:0]  t_key_vec;
    typedef logic [FLAG_COUNT-1:0] t_flag_vec;

    // Per-cell control: advance the partial matches, or clear them at end of message
    typedef struct packed {
        logic adv;
        logic clr;
    } t_cell_ctl;

    // Keyword text, right-aligned: first character in the highest used byte
    localparam logic [MAX_LEN*8-1:0] KEY_TEXT [KEY_COUNT] = '{
        "geoip:",
        "geosite:",
        "\"localhost\"",
        "\"127.0.0.1\"",
        "\"balancers\"",
        "\"balancerTag\"",
        "\"observatory\"",
        "\"burstObservatory\""
    };

    localparam logic [POS_W-1:0] KEY_LEN [KEY_COUNT] = '{
        POS_W'(6), POS_W'(8), POS_W'(11), POS_W'(11),
        POS_W'(11), POS_W'(13), POS_W'(13), POS_W'(18)
    };

    // Result flag that each keyword sets
    localparam int unsigned KEY_BIT [KEY_COUNT] = '{0, 1, 2, 2, 3, 3, 4, 4};

    // ASCII case folding per keyword
    localparam logic KEY_FOLD [KEY_COUNT] = '{1'b1, 1'b1, 1'b1, 1'b1,
                                              1'b0, 1'b0, 1'b0, 1'b0};

    // Fold A-Z to a-z, pass everything else
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // For each keyword: does byte b equal the keyword character at position pos
    function automatic t_key_vec char_hit(input logic [POS_W-1:0] pos, input logic [7:0] b);
        t_key_vec   v;
        logic [7:0] c;
        int         sh;
        for (int k = 0; k < KEY_COUNT; k++) begin
            v[k] = 1'b0;
            if (pos < KEY_LEN[k]) begin
                sh = (int'(KEY_LEN[k]) - 1 - int'(pos)) * 8;
                c  = KEY_TEXT[k][sh +: 8];
                if (KEY_FOLD[k]) begin
                    v[k] = (fold_byte(b) == fold_byte(c));
                end else begin
                    v[k] = (b == c);
                end
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mksd_cell.sv
// One cell of the match chain: holds partial keyword matches of one length.
`default_nettype none

module mksd_cell #(
    parameter int unsigned POS = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire mksd_pkg::t_cell_ctl i_ctl,
    input  wire  [7:0]           i_byte,
    input  wire mksd_pkg::t_key_vec  i_in,
    output mksd_pkg::t_key_vec   o_ext
);

    // Prefix of length POS+1 matched, ending at the previous byte
    mksd_pkg::t_key_vec r_prefix;
    mksd_pkg::t_key_vec n_prefix;

    // Extend the held prefixes by the current byte
    assign o_ext = r_prefix & mksd_pkg::char_hit(mksd_pkg::POS_W'(POS + 1), i_byte);

    // Load from the left neighbor on advance, drop everything at end of message
    always_comb begin
        n_prefix = r_prefix;
        priority if (i_ctl.clr) begin
            n_prefix = '0;
        end else if (i_ctl.adv) begin
            n_prefix = i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
        end else begin
            r_prefix <= n_prefix;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mksd_out_skid.sv
// Output register with one skid entry for the result stream.
`default_nettype none

module mksd_out_skid (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  wire  [mksd_pkg::OUT_W-1:0] i_data,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [mksd_pkg::OUT_W-1:0] o_data,
    input  wire                        i_ready
);

    logic                       r_out_valid;
    logic [mksd_pkg::OUT_W-1:0] r_out_data;
    logic                       r_skid_valid;
    logic [mksd_pkg::OUT_W-1:0] r_skid_data;
    logic                       w_out_free;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;

    // Control: refill output from skid first, park a new item in skid when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || (i_valid && !r_skid_valid);
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_valid) begin
                r_out_data <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/multi_keyword_stream_detector_top.sv
// Top level of the keyword stream detector: cell chain, sticky flags and result stage.
//
// Usage:
//   Input stream (i_s_*): one message byte per item in tdata[7:0], tlast on the
//   final byte of a message. Output stream (o_m_*): one item per message, sent
//   after its last byte, with five found flags in tdata[4:0].
//   Each cell of the chain holds partial keyword matches of one length and
//   passes them to its neighbor every accepted non-final byte, so all keywords (up to
//   18 bytes) are tracked in parallel.
//   Throughput: one byte per cycle while o_s_tready is high.
//   The last byte's result goes to the output register, or to the skid entry.
//   Reset clears the chain, the flags and the result stage; no clearing pass.
//   When the receiver stalls, bytes of the next message keep flowing; a
//   second finished result parks in the skid entry, and only then does
//   o_s_tready drop until the output drains.
`default_nettype none

module multi_keyword_stream_detector_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire  [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire        i_s_tlast,   // end_of_message
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata    // [0] geoip_found, [1] geosite_found,
                                    // [2] localhost_found, [3] balancer_found,
                                    // [4] observatory_found, [7:5] zero
);

    localparam int unsigned NC = mksd_pkg::CELL_COUNT;

    logic                 w_in_fire;
    mksd_pkg::t_cell_ctl  w_ctl;
    mksd_pkg::t_key_vec   w_first;
    mksd_pkg::t_key_vec   w_ext [NC];
    mksd_pkg::t_flag_vec  w_hits;
    mksd_pkg::t_flag_vec  r_flags;
    mksd_pkg::t_flag_vec  n_flags;
    logic [mksd_pkg::OUT_W-1:0] w_result;

    assign w_in_fire = i_s_tvalid && o_s_tready;
    assign w_ctl.adv = w_in_fire && !i_s_tlast;
    assign w_ctl.clr = w_in_fire && i_s_tlast;

    // Single-byte prefixes feed the head of the chain
    assign w_first = mksd_pkg::char_hit('0, i_s_tdata);

    // Chain of match cells
    for (genvar j = 0; j < NC; j++) begin : g_cell
        mksd_cell #(
            .POS (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_byte  (i_s_tdata),
            .i_in    ((j == 0) ? w_first : w_ext[(j == 0) ? 0 : j - 1]),
            .o_ext   (w_ext[j])
        );
    end

    // Collect full keyword matches ending at the current byte
    always_comb begin
        w_hits = '0;
        for (int k = 0; k < mksd_pkg::KEY_COUNT; k++) begin
            w_hits[mksd_pkg::KEY_BIT[k]] = w_hits[mksd_pkg::KEY_BIT[k]]
                | w_ext[int'(mksd_pkg::KEY_LEN[k]) - 2][k];
        end
    end

    // Sticky flags: accumulate, drop at end of message
    always_comb begin
        n_flags = r_flags;
        priority if (w_ctl.clr) begin
            n_flags = '0;
        end else if (w_ctl.adv) begin
            n_flags = r_flags | w_hits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    assign w_result = {{(mksd_pkg::OUT_W - mksd_pkg::FLAG_COUNT){1'b0}}, r_flags | w_hits};

    // Result stage
    mksd_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ctl.clr),
        .i_data  (w_result),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata),
        .i_ready (i_m_tready)
    );

`ifndef SYNTHESIS
    // Input is only stalled while a result waits at the output
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no pending result");

    // Flags start empty after each message end
    a_flags_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clr |=> (r_flags == '0))
        else $error("flags not cleared after message end");

    // A message end is always followed next cycle by a valid output (its own result or an older one)
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clr |=> o_m_tvalid)
        else $error("result missing after message end");

    // Flags never drop inside a message
    a_flags_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.adv |=> ((r_flags & $past(r_flags)) == $past(r_flags)))
        else $error("sticky flag lost within message");
`endif

endmodule

`default_nettype wire
